[rtl/letter_huffman_codec_macros.svh]
// Assertion macros for the letter Huffman codec.
// Used by lhc_ctrl; no other dependencies.
`ifndef LETTER_HUFFMAN_CODEC_MACROS_SVH
`define LETTER_HUFFMAN_CODEC_MACROS_SVH

// same-cycle implication
`define LHC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lhc assertion failed");

// next-cycle implication
`define LHC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lhc assertion failed");

`endif

[rtl/lhc_pkg.sv]
// Package for the letter Huffman codec: sizes, codes, FSM type, control structs.
// No dependencies.
`timescale 1ns / 1ps

package lhc_pkg;

    localparam int ALPHABET    = 26;
    localparam int COUNT_WIDTH = 24;
    localparam int NSLOT       = 2 * ALPHABET - 1;
    localparam int SYM_W       = $clog2(ALPHABET);
    localparam int NODE_W      = $clog2(NSLOT);
    localparam int LEAF_W      = $clog2(ALPHABET + 1);
    localparam int WT_W        = COUNT_WIDTH + $clog2(ALPHABET);
    localparam int CW_W        = ALPHABET - 1;
    localparam int LEN_W       = $clog2(ALPHABET);

    // fixed field widths
    localparam int CMD_W       = 3;
    localparam int KIND_W      = 2;
    localparam int CODE_BITS_W = 25;
    localparam int CODE_LEN_W  = 5;
    localparam int WB_W        = 34;
    localparam int TOT_W       = 29;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BUILD  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DECODE = 3'd4;

    localparam logic [KIND_W-1:0] KIND_CODE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LETTER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BUILD  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd3;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_UA   = 8'h41;
    localparam logic [7:0] CHAR_UZ   = 8'h5A;
    localparam logic [7:0] CHAR_LA   = 8'h61;
    localparam logic [7:0] CHAR_LZ   = 8'h7A;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_SCAN_END,
        S_MERGE,
        S_DONE,
        S_DEC_RD
    } t_state;

    typedef struct packed {
        logic take;      // input transfer this cycle
        logic load;      // load one letter as a leaf
        logic scan;      // issue a weight read
        logic merge;     // join the two lightest nodes
        logic done;      // present the build result
        logic dec;       // finish a decode step
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic load_last;
        logic tree_small;
        logic scan_last;
        logic merge_last;
        logic dec_go;
    } t_stat;

    typedef struct packed {
        logic             ok;
        logic [SYM_W-1:0] idx;
    } t_lidx;

    function automatic t_lidx letter_index(logic [7:0] b);
        t_lidx      r;
        logic [7:0] f;
        f     = (b >= CHAR_UA && b <= CHAR_UZ) ? 8'(b + 8'd32) : b;
        r.ok  = (f >= CHAR_LA) && (f <= CHAR_LZ) && (8'(f - CHAR_LA) < 8'(ALPHABET));
        r.idx = SYM_W'(8'(f - CHAR_LA));
        return r;
    endfunction

endpackage

[rtl/lhc_if.sv]
// Valid/ready channel interfaces for the letter Huffman codec.
// Depends on lhc_pkg.
`timescale 1ns / 1ps

interface lhc_in_if;
    logic                        valid;
    logic                        ready;
    logic [lhc_pkg::CMD_W-1:0]   command;
    logic [7:0]                  byte_value;

    modport source (output valid, command, byte_value, input ready);
    modport sink   (input valid, command, byte_value, output ready);
endinterface

interface lhc_out_if;
    logic                            valid;
    logic                            ready;
    logic [lhc_pkg::KIND_W-1:0]      kind;
    logic [lhc_pkg::CODE_BITS_W-1:0] code_bits;
    logic [lhc_pkg::CODE_LEN_W-1:0]  code_length;
    logic [7:0]                      letter;
    logic [lhc_pkg::WB_W-1:0]        weighted_bits;
    logic [lhc_pkg::TOT_W-1:0]       letter_total;

    modport source (output valid, kind, code_bits, code_length, letter, weighted_bits,
                    letter_total, input ready);
    modport sink   (input valid, kind, code_bits, code_length, letter, weighted_bits,
                    letter_total, output ready);
endinterface

[rtl/lhc_ctrl.sv]
// Sequencer for the letter Huffman codec: accepts commands, steps the build.
// Depends on lhc_pkg and letter_huffman_codec_macros.svh.
`timescale 1ns / 1ps
`include "letter_huffman_codec_macros.svh"

module lhc_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [lhc_pkg::CMD_W-1:0] i_command,
    input  lhc_pkg::t_stat            i_stat,
    output logic                      o_ready,
    output lhc_pkg::t_cmd             o_cmd
);

    lhc_pkg::t_state r_state, n_state;
    logic            take;

    assign o_ready = (r_state == lhc_pkg::S_IDLE) && i_stat.out_free;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lhc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lhc_pkg::S_IDLE: begin
                if (take && i_command == lhc_pkg::CMD_BUILD) begin
                    n_state = lhc_pkg::S_LOAD;
                end else if (take && i_command == lhc_pkg::CMD_DECODE && i_stat.dec_go) begin
                    n_state = lhc_pkg::S_DEC_RD;
                end
            end
            lhc_pkg::S_LOAD: begin
                if (i_stat.load_last) begin
                    n_state = i_stat.tree_small ? lhc_pkg::S_DONE : lhc_pkg::S_SCAN;
                end
            end
            lhc_pkg::S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = lhc_pkg::S_SCAN_END;
                end
            end
            lhc_pkg::S_SCAN_END: n_state = lhc_pkg::S_MERGE;
            lhc_pkg::S_MERGE: begin
                n_state = i_stat.merge_last ? lhc_pkg::S_DONE : lhc_pkg::S_SCAN;
            end
            lhc_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = lhc_pkg::S_IDLE;
                end
            end
            lhc_pkg::S_DEC_RD: n_state = lhc_pkg::S_IDLE;
            default: n_state = lhc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.take  = take;
        unique case (r_state)
            lhc_pkg::S_LOAD:   o_cmd.load  = 1'b1;
            lhc_pkg::S_SCAN:   o_cmd.scan  = 1'b1;
            lhc_pkg::S_MERGE:  o_cmd.merge = 1'b1;
            lhc_pkg::S_DONE:   o_cmd.done  = i_stat.out_free;
            lhc_pkg::S_DEC_RD: o_cmd.dec   = 1'b1;
            default: ;
        endcase
    end

    `LHC_ASSERT_NXT(a_build_loads, i_clk, i_rst_n, take && i_command == lhc_pkg::CMD_BUILD, r_state == lhc_pkg::S_LOAD)
    `LHC_ASSERT_NXT(a_dec_reads, i_clk, i_rst_n, take && i_command == lhc_pkg::CMD_DECODE && i_stat.dec_go, r_state == lhc_pkg::S_DEC_RD)
    `LHC_ASSERT_NXT(a_done_leaves, i_clk, i_rst_n, r_state == lhc_pkg::S_DONE && i_stat.out_free, r_state == lhc_pkg::S_IDLE)

endmodule

[rtl/lhc_datapath.sv]
// Datapath of the letter Huffman codec: counts, node memories, codes, result register.
// Depends on lhc_pkg.
`timescale 1ns / 1ps

module lhc_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lhc_pkg::t_cmd                   i_cmd,
    output lhc_pkg::t_stat                  o_stat,
    input  logic [lhc_pkg::CMD_W-1:0]       i_command,
    input  logic [7:0]                      i_byte,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [lhc_pkg::KIND_W-1:0]      o_kind,
    output logic [lhc_pkg::CODE_BITS_W-1:0] o_code_bits,
    output logic [lhc_pkg::CODE_LEN_W-1:0]  o_code_length,
    output logic [7:0]                      o_letter,
    output logic [lhc_pkg::WB_W-1:0]        o_weighted_bits,
    output logic [lhc_pkg::TOT_W-1:0]       o_letter_total
);

    localparam int SYM_W  = lhc_pkg::SYM_W;
    localparam int NODE_W = lhc_pkg::NODE_W;
    localparam int WT_W   = lhc_pkg::WT_W;
    localparam int CNT_W  = lhc_pkg::COUNT_WIDTH;

    // letter store
    logic [CNT_W-1:0]             r_count [lhc_pkg::ALPHABET];
    logic [lhc_pkg::CW_W-1:0]     r_word  [lhc_pkg::ALPHABET];
    logic [lhc_pkg::LEN_W-1:0]    r_len   [lhc_pkg::ALPHABET];
    logic [NODE_W-1:0]            r_grp   [lhc_pkg::ALPHABET];
    logic [SYM_W-1:0]             r_leaf_sym [lhc_pkg::ALPHABET];
    logic [lhc_pkg::ALPHABET-1:0] r_ok;

    // node memories
    logic [WT_W-1:0]     mem_wt [lhc_pkg::NSLOT];
    logic [2*NODE_W-1:0] mem_ch [lhc_pkg::NSLOT];
    logic [WT_W-1:0]     r_wt_q;
    logic [2*NODE_W-1:0] r_ch_q;
    logic [lhc_pkg::NSLOT-1:0] r_live;

    logic [lhc_pkg::LEAF_W-1:0] r_leaves;
    logic [NODE_W-1:0]          r_root, r_walk;
    logic [SYM_W-1:0]           r_s;
    logic [NODE_W-1:0]          r_n, r_idx, r_pidx;
    logic                       r_pv;
    logic                       r_f1, r_f2;
    logic [NODE_W-1:0]          r_i1, r_i2;
    logic [WT_W-1:0]            r_w1, r_w2;
    logic [WT_W-1:0]            r_total;
    logic [lhc_pkg::WB_W-1:0]   r_weighted;
    logic                       r_dec_bit;

    lhc_pkg::t_lidx    lid;
    logic [SYM_W-1:0]  cnt_addr;
    logic [CNT_W-1:0]  cnt_rd;
    logic              is_bit;
    logic [NODE_W-1:0] dec_next;
    logic [NODE_W:0]   n_plus;
    logic [WT_W-1:0]   merge_sum;
    logic              take_enc, take_dec;

    assign lid       = lhc_pkg::letter_index(i_byte);
    assign cnt_addr  = i_cmd.load ? r_s : lid.idx;
    assign cnt_rd    = r_count[cnt_addr];
    assign is_bit    = (i_byte == lhc_pkg::CHAR_ZERO) || (i_byte == lhc_pkg::CHAR_ONE);
    assign dec_next  = r_dec_bit ? r_ch_q[NODE_W-1:0] : r_ch_q[2*NODE_W-1:NODE_W];
    assign n_plus    = (NODE_W+1)'(r_n) + (NODE_W+1)'(cnt_rd != '0);
    assign merge_sum = r_w1 + r_w2;
    assign take_enc  = i_cmd.take && i_command == lhc_pkg::CMD_ENCODE;
    assign take_dec  = i_cmd.take && i_command == lhc_pkg::CMD_DECODE;

    assign o_stat.out_free   = !o_out_valid || i_out_ready;
    assign o_stat.load_last  = (r_s == SYM_W'(lhc_pkg::ALPHABET - 1));
    assign o_stat.tree_small = (n_plus < (NODE_W+1)'(2));
    assign o_stat.scan_last  = ((NODE_W+1)'(r_idx) + 1'b1 == (NODE_W+1)'(r_n));
    assign o_stat.merge_last = ((NODE_W+1)'(r_n) + 1'b1
                               == ((NODE_W+1)'(r_leaves) << 1) - 1'b1);
    assign o_stat.dec_go     = (r_leaves >= 2) && is_bit;

    // node memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && cnt_rd != '0) begin
            mem_wt[r_n] <= WT_W'(cnt_rd);
            mem_ch[r_n] <= '0;
        end else if (i_cmd.merge) begin
            mem_wt[r_n] <= merge_sum;
            mem_ch[r_n] <= {r_i1, r_i2};
        end
        r_wt_q <= mem_wt[r_idx];
        r_ch_q <= mem_ch[r_walk];
    end

    // letter counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < lhc_pkg::ALPHABET; s++) begin
                r_count[s] <= '0;
            end
        end else if (i_cmd.take && i_command == lhc_pkg::CMD_CLEAR) begin
            for (int s = 0; s < lhc_pkg::ALPHABET; s++) begin
                r_count[s] <= '0;
            end
        end else if (i_cmd.take && i_command == lhc_pkg::CMD_COUNT && lid.ok
                     && cnt_rd != '1) begin
            r_count[lid.idx] <= cnt_rd + 1'b1;
        end
    end

    // codes: leaves pick up one bit at each merge of their subtree
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= '0;
        end else if (i_cmd.load) begin
            r_ok[r_s] <= (cnt_rd != '0);
            r_word[r_s] <= '0;
            r_len[r_s] <= '0;
            r_grp[r_s] <= r_n;
            r_leaf_sym[r_n[SYM_W-1:0]] <= r_s;
        end else if (i_cmd.merge) begin
            for (int s = 0; s < lhc_pkg::ALPHABET; s++) begin
                if (r_ok[s] && r_grp[s] == r_i1) begin
                    r_len[s] <= r_len[s] + 1'b1;
                    r_grp[s] <= r_n;
                end else if (r_ok[s] && r_grp[s] == r_i2) begin
                    r_word[s] <= r_word[s] | (lhc_pkg::CW_W'(1) << r_len[s]);
                    r_len[s] <= r_len[s] + 1'b1;
                    r_grp[s] <= r_n;
                end
            end
        end
    end

    // build sequencing and search for the two lightest live nodes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaves <= '0;
            r_root   <= '0;
            r_walk   <= '0;
            r_pv     <= 1'b0;
        end else begin
            r_pv   <= i_cmd.scan;
            r_pidx <= r_idx;
            if (i_cmd.take && i_command == lhc_pkg::CMD_BUILD) begin
                r_s        <= '0;
                r_n        <= '0;
                r_total    <= '0;
                r_weighted <= '0;
                r_live     <= '0;
            end
            if (i_cmd.load) begin
                r_s     <= r_s + 1'b1;
                r_total <= r_total + WT_W'(cnt_rd);
                if (cnt_rd != '0) begin
                    r_live[r_n] <= 1'b1;
                    r_n         <= r_n + 1'b1;
                end
                if (o_stat.load_last) begin
                    r_leaves <= lhc_pkg::LEAF_W'(n_plus);
                    r_idx    <= '0;
                    r_f1     <= 1'b0;
                    r_f2     <= 1'b0;
                end
            end
            if (i_cmd.scan) begin
                r_idx <= r_idx + 1'b1;
            end
            // ties keep the earlier index
            if (r_pv && r_live[r_pidx]) begin
                if (!r_f1 || r_wt_q < r_w1) begin
                    r_w2 <= r_w1;
                    r_i2 <= r_i1;
                    r_f2 <= r_f1;
                    r_w1 <= r_wt_q;
                    r_i1 <= r_pidx;
                    r_f1 <= 1'b1;
                end else if (!r_f2 || r_wt_q < r_w2) begin
                    r_w2 <= r_wt_q;
                    r_i2 <= r_pidx;
                    r_f2 <= 1'b1;
                end
            end
            if (i_cmd.merge) begin
                r_live[r_i1] <= 1'b0;
                r_live[r_i2] <= 1'b0;
                r_live[r_n]  <= 1'b1;
                r_n          <= r_n + 1'b1;
                r_weighted   <= r_weighted + lhc_pkg::WB_W'(merge_sum);
                r_idx        <= '0;
                r_f1         <= 1'b0;
                r_f2         <= 1'b0;
            end
            if (i_cmd.done) begin
                r_root <= (r_n == '0) ? '0 : r_n - 1'b1;
                r_walk <= (r_n == '0) ? '0 : r_n - 1'b1;
            end
            if (take_dec && r_leaves >= 2 && !is_bit) begin
                r_walk <= r_root;
            end
            if (take_dec) begin
                r_dec_bit <= (i_byte == lhc_pkg::CHAR_ONE);
            end
            if (i_cmd.dec) begin
                r_walk <= (dec_next < NODE_W'(r_leaves)) ? r_root : dec_next;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if ((take_enc && lid.ok && r_ok[lid.idx])
                || (take_dec && !(r_leaves >= 2 && is_bit))
                || (i_cmd.dec && dec_next < NODE_W'(r_leaves))
                || i_cmd.done) begin
                o_out_valid <= 1'b1;
            end
        end
        if (i_cmd.take || i_cmd.dec || i_cmd.done) begin
            o_kind          <= lhc_pkg::KIND_ERROR;
            o_code_bits     <= '0;
            o_code_length   <= '0;
            o_letter        <= '0;
            o_weighted_bits <= '0;
            o_letter_total  <= '0;
            if (take_enc) begin
                o_kind        <= lhc_pkg::KIND_CODE;
                o_code_bits   <= lhc_pkg::CODE_BITS_W'(32'(r_word[lid.idx]));
                o_code_length <= lhc_pkg::CODE_LEN_W'(r_len[lid.idx]);
            end else if (i_cmd.dec) begin
                o_kind   <= lhc_pkg::KIND_LETTER;
                o_letter <= 8'(lhc_pkg::CHAR_LA + 8'(r_leaf_sym[dec_next[SYM_W-1:0]]));
            end else if (i_cmd.done) begin
                o_kind          <= lhc_pkg::KIND_BUILD;
                o_weighted_bits <= r_weighted;
                o_letter_total  <= lhc_pkg::TOT_W'(r_total);
            end
        end
    end

endmodule

[rtl/letter_huffman_codec.sv]
// Letter Huffman codec: top level joining sequencer and datapath.
// Depends on lhc_pkg, lhc_if, lhc_ctrl, lhc_datapath.
//
// Usage:
//   i_in  carries command and byte_value; a transfer is valid && ready.
//   o_out carries one result item per transfer: kind, code_bits,
//   code_length, letter, weighted_bits, letter_total (unused fields zero).
//   Clear, count and encode are each accepted in a single transfer; encode's
//   code word is in the result register on the next cycle.
//   Decode handles each code character in two steps: first read the child
//   pair of the current node, then step and emit a letter at a leaf.
//   Build: load each of the 26 letters as a leaf, then per merge scan every
//   node made so far (L to 2L-2 with L leaves), pass S_SCAN_END and do the
//   merge, then post the result.
//   The result sits in an output register; a new item is taken while it is
//   being transferred. When the receiver stalls, input stays blocked once
//   the register holds an untaken result.
//   Reset clears the letter counts, the code valid bits, the leaf count and
//   the root and walk pointers; no memory sweep is needed.
`timescale 1ns / 1ps

module letter_huffman_codec (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lhc_in_if.sink    i_in,
    lhc_out_if.source o_out
);

    lhc_pkg::t_cmd  cmd;
    lhc_pkg::t_stat stat;

    lhc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_command (i_in.command),
        .i_stat    (stat),
        .o_ready   (i_in.ready),
        .o_cmd     (cmd)
    );

    lhc_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_command       (i_in.command),
        .i_byte          (i_in.byte_value),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_kind          (o_out.kind),
        .o_code_bits     (o_out.code_bits),
        .o_code_length   (o_out.code_length),
        .o_letter        (o_out.letter),
        .o_weighted_bits (o_out.weighted_bits),
        .o_letter_total  (o_out.letter_total)
    );

endmodule

[tb/sv/tb.sv]
// Self-checking bench for letter_huffman_codec: directed table, then random phases.
// Depends on lhc_pkg, lhc_if and the codec RTL; all results checked by a local predictor.
`timescale 1ns / 1ps

module tb;
    import lhc_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [CODE_BITS_W-1:0] code_bits;
        logic [CODE_LEN_W-1:0]  code_length;
        logic [7:0]             letter;
        logic [WB_W-1:0]        weighted_bits;
        logic [TOT_W-1:0]       letter_total;
    } t_result;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [7:0]        value;
        logic              fixed;
        logic [KIND_W-1:0] kind;
    } t_row;

    localparam int WATCH_LIMIT = 5000;
    localparam int N_ITEMS     = 650;

    logic i_clk;
    logic i_rst_n;
    lhc_in_if  in_ch();
    lhc_out_if out_ch();

    letter_huffman_codec u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predictor state
    logic [COUNT_WIDTH-1:0] tally [ALPHABET];
    logic [TOT_W-1:0]       node_wt [NSLOT];
    int                     node_left [NSLOT];
    int                     node_right [NSLOT];
    logic [CODE_BITS_W-1:0] sym_code [ALPHABET];
    int                     sym_len [ALPHABET];
    bit                     sym_ok [ALPHABET];
    int                     leaf_sym [ALPHABET];
    int                     tree_root, walk_at, n_leaves;

    t_result pending_results [$];
    int      gap_max;
    int      n_items, n_results, n_builds, n_letters, n_fails;
    int      idle_cycles;
    int      sink_wait;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int fold_letter(logic [7:0] b);
        logic [7:0] f;
        f = (b >= CHAR_UA && b <= CHAR_UZ) ? b + 8'd32 : b;
        if (f < CHAR_LA || f > CHAR_LZ || int'(f - CHAR_LA) >= ALPHABET)
            return -1;
        return int'(f - CHAR_LA);
    endfunction

    function automatic int lightest(bit live [NSLOT], int n);
        int best;
        bit found;
        best  = 0;
        found = 0;
        for (int i = 0; i < n; i++)
            if (live[i] && (!found || node_wt[i] < node_wt[best])) begin
                best  = i;
                found = 1;
            end
        return best;
    endfunction

    function automatic void build_codes(output t_result r);
        bit            live [NSLOT];
        int            up [NSLOT];
        bit            side [NSLOT];
        int            n, a, b, k, len;
        logic [63:0]   weighted, total;
        logic [CODE_BITS_W-1:0] w;
        n = 0;
        weighted = 0;
        total = 0;
        r = '0;
        for (int i = 0; i < NSLOT; i++) begin
            live[i] = 0;
            up[i] = 0;
            side[i] = 0;
        end
        for (int s = 0; s < ALPHABET; s++) begin
            sym_ok[s] = 0;
            sym_code[s] = '0;
            sym_len[s] = 0;
            if (tally[s] != 0) begin
                leaf_sym[n] = s;
                node_wt[n] = TOT_W'(tally[s]);
                live[n] = 1;
                n++;
            end
        end
        n_leaves = n;
        for (int m = 1; m < n_leaves; m++) begin
            a = lightest(live, n);
            live[a] = 0;
            b = lightest(live, n);
            live[b] = 0;
            node_wt[n] = node_wt[a] + node_wt[b];
            node_left[n] = a;
            node_right[n] = b;
            up[a] = n; side[a] = 0;
            up[b] = n; side[b] = 1;
            live[n] = 1;
            n++;
        end
        tree_root = (n == 0) ? 0 : n - 1;
        walk_at = tree_root;
        for (int i = 0; i < n_leaves; i++) begin
            w = '0;
            len = 0;
            k = i;
            while (k != tree_root) begin
                w[len] = side[k];
                len++;
                k = up[k];
            end
            sym_code[leaf_sym[i]] = w;
            sym_len[leaf_sym[i]] = len;
            sym_ok[leaf_sym[i]] = 1;
        end
        for (int s = 0; s < ALPHABET; s++) begin
            total += tally[s];
            if (sym_ok[s])
                weighted += 64'(tally[s]) * sym_len[s];
        end
        r.kind = KIND_BUILD;
        r.weighted_bits = WB_W'(weighted);
        r.letter_total = TOT_W'(total);
    endfunction

    // returns 1 when the command yields a result
    function automatic bit codec_step(logic [CMD_W-1:0] cmd, logic [7:0] b, output t_result r);
        int idx, nxt;
        r = '0;
        idx = fold_letter(b);
        case (cmd)
            CMD_CLEAR: begin
                for (int s = 0; s < ALPHABET; s++) tally[s] = '0;
                return 0;
            end
            CMD_COUNT: begin
                if (idx >= 0 && tally[idx] != '1) tally[idx]++;
                return 0;
            end
            CMD_BUILD: begin
                build_codes(r);
                return 1;
            end
            CMD_ENCODE: begin
                if (idx < 0 || !sym_ok[idx]) return 0;
                r.kind = KIND_CODE;
                r.code_bits = sym_code[idx];
                r.code_length = CODE_LEN_W'(sym_len[idx]);
                return 1;
            end
            CMD_DECODE: begin
                r.kind = KIND_ERROR;
                if (n_leaves < 2) return 1;
                if (b != CHAR_ZERO && b != CHAR_ONE) begin
                    walk_at = tree_root;
                    return 1;
                end
                nxt = (b == CHAR_ZERO) ? node_left[walk_at] : node_right[walk_at];
                walk_at = nxt;
                if (walk_at < n_leaves) begin
                    r.kind = KIND_LETTER;
                    r.letter = CHAR_LA + 8'(leaf_sym[walk_at]);
                    walk_at = tree_root;
                    return 1;
                end
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    task automatic send(logic [CMD_W-1:0] cmd, logic [7:0] b, bit fixed = 0,
                        logic [KIND_W-1:0] fixed_kind = KIND_CODE);
        int      gap;
        t_result r;
        bit      has;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.byte_value <= b;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        has = codec_step(cmd, b, r);
        if (fixed) begin
            r = '0;
            r.kind = fixed_kind;
        end
        if (has) pending_results.push_back(r);
        n_items++;
    endtask

    task automatic cmp(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            n_fails++;
        end
    endtask

    // result sink with random stalls
    always @(posedge i_clk) begin
        t_result e;
        if (out_ch.valid && out_ch.ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer, kind %0d", out_ch.kind);
                n_fails++;
            end else begin
                e = pending_results.pop_front();
                cmp("kind", e.kind, out_ch.kind);
                cmp("code_bits", e.code_bits, out_ch.code_bits);
                cmp("code_length", e.code_length, out_ch.code_length);
                cmp("letter", e.letter, out_ch.letter);
                cmp("weighted_bits", e.weighted_bits, out_ch.weighted_bits);
                cmp("letter_total", e.letter_total, out_ch.letter_total);
                if (e.kind == KIND_BUILD) n_builds++;
                if (e.kind == KIND_LETTER) n_letters++;
            end
            sink_wait = $urandom_range(0, gap_max);
        end else if (sink_wait > 0) begin
            sink_wait--;
        end
        out_ch.ready <= (sink_wait == 0);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // well-formed code string for one coded letter, or one bit if no letter has a non-empty code
    task automatic decode_word();
        int s;
        s = $urandom_range(0, ALPHABET - 1);
        for (int i = 0; i < ALPHABET && !sym_ok[s]; i++) s = (s + 1) % ALPHABET;
        if (!sym_ok[s] || sym_len[s] == 0) begin
            send(CMD_DECODE, $urandom_range(0, 1) ? CHAR_ONE : CHAR_ZERO);
            return;
        end
        for (int i = sym_len[s] - 1; i >= 0; i--)
            send(CMD_DECODE, sym_code[s][i] ? CHAR_ONE : CHAR_ZERO);
    endtask

    t_row dir_rows [] = '{
        '{CMD_DECODE, CHAR_ZERO, 1'b1, KIND_ERROR},   // no tree yet
        '{CMD_BUILD,  8'h00,     1'b1, KIND_BUILD},   // nothing counted
        '{CMD_ENCODE, CHAR_LA,   1'b0, KIND_CODE},    // no code: silent
        '{CMD_COUNT,  "m",       1'b0, KIND_CODE},
        '{CMD_BUILD,  8'hFF,     1'b0, KIND_CODE},
        '{CMD_ENCODE, "M",       1'b1, KIND_CODE},    // single symbol, empty code
        '{CMD_DECODE, CHAR_ONE,  1'b1, KIND_ERROR},
        '{CMD_CLEAR,  8'h00,     1'b0, KIND_CODE},
        '{CMD_COUNT,  CHAR_UA,   1'b0, KIND_CODE},
        '{CMD_COUNT,  CHAR_LA,   1'b0, KIND_CODE},
        '{CMD_COUNT,  CHAR_LZ,   1'b0, KIND_CODE},
        '{CMD_COUNT,  CHAR_UZ,   1'b0, KIND_CODE},
        '{CMD_COUNT,  "q",       1'b0, KIND_CODE},
        '{CMD_COUNT,  8'hFF,     1'b0, KIND_CODE},
        '{CMD_COUNT,  "@",       1'b0, KIND_CODE},
        '{CMD_COUNT,  "{",       1'b0, KIND_CODE},
        '{CMD_BUILD,  8'h00,     1'b0, KIND_CODE},
        '{CMD_ENCODE, CHAR_UZ,   1'b0, KIND_CODE},
        '{CMD_ENCODE, "q",       1'b0, KIND_CODE},
        '{CMD_DECODE, CHAR_ONE,  1'b0, KIND_CODE},
        '{CMD_DECODE, "x",       1'b1, KIND_ERROR},
        '{CMD_DECODE, CHAR_ZERO, 1'b0, KIND_CODE},
        '{3'd5,       8'h55,     1'b0, KIND_CODE},
        '{3'd7,       8'hAA,     1'b0, KIND_CODE},
        '{3'd6,       CHAR_ONE,  1'b0, KIND_CODE}
    };

    initial begin
        int n, span, base, pick;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_CLEAR;
        in_ch.byte_value = 8'h00;
        out_ch.ready = 1'b0;
        sink_wait = 0;
        idle_cycles = 0;
        gap_max = 0;
        n_items = 0; n_results = 0; n_builds = 0; n_letters = 0; n_fails = 0;
        for (int s = 0; s < ALPHABET; s++) begin
            tally[s] = '0;
            sym_ok[s] = 0;
        end
        tree_root = 0; walk_at = 0; n_leaves = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].fixed, dir_rows[i].kind);

        while (n_items < N_ITEMS) begin
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
            if ($urandom_range(0, 3) != 0) send(CMD_CLEAR, 8'($urandom));
            // skewed letter mix over a random slice of the alphabet
            span = $urandom_range(1, ALPHABET);
            base = $urandom_range(0, ALPHABET - span);
            n = $urandom_range(5, 40);
            for (int i = 0; i < n; i++) begin
                pick = base + ($urandom_range(0, span - 1) * $urandom_range(0, span - 1)) / span;
                case ($urandom_range(0, 9))
                    0:       send(CMD_COUNT, 8'($urandom));
                    1, 2:    send(CMD_COUNT, CHAR_UA + 8'(pick));
                    default: send(CMD_COUNT, CHAR_LA + 8'(pick));
                endcase
            end
            send(CMD_BUILD, 8'($urandom));
            n = $urandom_range(8, 20);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 9))
                    0:       send(CMD_DECODE, 8'($urandom));
                    1:       send(CMD_ENCODE, 8'($urandom));
                    2:       send(3'($urandom_range(5, 7)), 8'($urandom));
                    3, 4:    send(CMD_ENCODE, ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA)
                                              + 8'($urandom_range(0, ALPHABET - 1)));
                    default: decode_word();
                endcase
            end
        end

        // drop valid at the edge of the last transfer so it is not taken twice
        in_ch.valid <= 1'b0;
        gap_max = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            n_fails++;
        end
        $display("Ran %0d commands, checked %0d results: %0d builds, %0d decoded letters.",
                 n_items, n_results, n_builds, n_letters);
        if (n_fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
